// File: hw/rtl/tea_ctr_pkg.sv
// Shared types, constants and the TEA half-round function for the counter-mode cipher.
package tea_ctr_pkg;

  localparam int unsigned WordW  = 32;
  localparam int unsigned BlockW = 64;
  localparam int unsigned CfgIdxW = 3;

  localparam logic [WordW-1:0] TEA_DELTA = 32'h9E37_79B9;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_KEY0  = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_KEY1  = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_KEY2  = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_KEY3  = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_NONCE = 3'd4;

  typedef struct packed {
    logic [WordW-1:0] k0;
    logic [WordW-1:0] k1;
    logic [WordW-1:0] k2;
    logic [WordW-1:0] k3;
  } key_t;

  // Payload carried down the round pipeline
  typedef struct packed {
    logic [WordW-1:0]  v1;
    logic [WordW-1:0]  v0;
    logic [BlockW-1:0] data;
  } lane_t;

  // TEA mixing term: ((x << 4) + ka) ^ (x + sum) ^ ((x >> 5) + kb)
  function automatic logic [WordW-1:0] tea_mix(
    input logic [WordW-1:0] x,
    input logic [WordW-1:0] ka,
    input logic [WordW-1:0] kb,
    input logic [WordW-1:0] sum
  );
    tea_mix = ((x << 4) + ka) ^ (x + sum) ^ ((x >> 5) + kb);
  endfunction

endpackage

// File: hw/rtl/tea_ctr_keystream_cipher_top.sv
// Top level: counter-mode TEA keystream cipher, fully unrolled round pipeline.
//
// One request is taken every clock cycle: busy is always low and the result
// receiver cannot stall. Each request passes through one entry stage that
// forms the counter from block index and nonce, then through the TEA rounds,
// each split into two registered half rounds, and through a final register
// that XORs the keystream into the data block. out_valid pulses for one cycle
// with out_result_block. The nonce is read live by the entry stage and the key
// by every half round, so write them only while the pipeline is empty.
module tea_ctr_keystream_cipher_top #(
  parameter int unsigned ROUNDS = 1024
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  output logic                                  busy,
  input  logic [tea_ctr_pkg::BlockW-1:0]        in_data_block,
  input  logic [tea_ctr_pkg::WordW-1:0]         in_block_index,
  output logic                                  out_valid,
  output logic [tea_ctr_pkg::BlockW-1:0]        out_result_block,
  input  logic                                  cfg_we,
  input  logic [tea_ctr_pkg::CfgIdxW-1:0]       cfg_index,
  input  logic [tea_ctr_pkg::BlockW-1:0]        cfg_wdata
);

  localparam int unsigned STAGES  = 2 * ROUNDS;
  localparam int unsigned LATENCY = STAGES + 2;

  tea_ctr_pkg::key_t              key;
  logic [tea_ctr_pkg::BlockW-1:0] nonce;

  logic               vld  [0:STAGES];
  tea_ctr_pkg::lane_t lane [0:STAGES];

  logic                           entry_vld_r;
  tea_ctr_pkg::lane_t             entry_lane_r;
  logic                           out_valid_r;
  logic [tea_ctr_pkg::BlockW-1:0] out_result_block_r;
  logic                           accept;

  // Pipeline never stalls
  assign busy   = 1'b0;
  assign accept = start & ~busy;

  tea_ctr_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .key       (key),
    .nonce     (nonce)
  );

  // Entry stage: counter = zero-extended index XOR nonce
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_vld_r <= 1'b0;
    end else begin
      entry_vld_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    entry_lane_r.v0   <= nonce[tea_ctr_pkg::WordW-1:0] ^ in_block_index;
    entry_lane_r.v1   <= nonce[tea_ctr_pkg::BlockW-1:tea_ctr_pkg::WordW];
    entry_lane_r.data <= in_data_block;
  end

  assign vld[0]  = entry_vld_r;
  assign lane[0] = entry_lane_r;

  // Unrolled half rounds
  for (genvar s = 0; s < STAGES; s++) begin : g_stage
    tea_ctr_half_round #(
      .ROUND_IDX (s / 2),
      .ODD_HALF  (1'((s % 2)))
    ) u_half (
      .clk      (clk),
      .rst_n    (rst_n),
      .key      (key),
      .vld_in   (vld[s]),
      .lane_in  (lane[s]),
      .vld_out  (vld[s+1]),
      .lane_out (lane[s+1])
    );
  end

  // Output register: data XOR keystream (v1:v0)
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= vld[STAGES];
    end
  end

  always_ff @(posedge clk) begin
    out_result_block_r <= lane[STAGES].data ^ {lane[STAGES].v1, lane[STAGES].v0};
  end

  assign out_valid        = out_valid_r;
  assign out_result_block = out_result_block_r;

  // Every result strobe traces back to an earlier accepted request
  a_out_from_req: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept, LATENCY))
    else $error("result strobe without matching request");

  // An accepted request enters the entry stage on the next cycle
  a_entry_valid: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> vld[0])
    else $error("request lost at pipeline entry");

  // Last half-round valid is followed by a result strobe
  a_exit_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    vld[STAGES] |=> out_valid)
    else $error("pipeline exit did not produce a result");

endmodule

// File: hw/rtl/tea_ctr_cfg.sv
// Configuration register file: four key words and the 64-bit nonce.
module tea_ctr_cfg (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [tea_ctr_pkg::CfgIdxW-1:0]      cfg_index,
  input  logic [tea_ctr_pkg::BlockW-1:0]       cfg_wdata,
  output tea_ctr_pkg::key_t                    key,
  output logic [tea_ctr_pkg::BlockW-1:0]       nonce
);

  tea_ctr_pkg::key_t                    key_r;
  logic [tea_ctr_pkg::BlockW-1:0]       nonce_r;

  // Register writes; indexes past the list are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r   <= '0;
      nonce_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        tea_ctr_pkg::CFG_KEY0:  key_r.k0 <= cfg_wdata[tea_ctr_pkg::WordW-1:0];
        tea_ctr_pkg::CFG_KEY1:  key_r.k1 <= cfg_wdata[tea_ctr_pkg::WordW-1:0];
        tea_ctr_pkg::CFG_KEY2:  key_r.k2 <= cfg_wdata[tea_ctr_pkg::WordW-1:0];
        tea_ctr_pkg::CFG_KEY3:  key_r.k3 <= cfg_wdata[tea_ctr_pkg::WordW-1:0];
        tea_ctr_pkg::CFG_NONCE: nonce_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign key   = key_r;
  assign nonce = nonce_r;

endmodule

// File: hw/rtl/tea_ctr_half_round.sv
// One registered half round of TEA: updates v0 (even half) or v1 (odd half).
module tea_ctr_half_round #(
  parameter int unsigned ROUND_IDX = 0,
  parameter bit          ODD_HALF  = 1'b0
) (
  input  logic                clk,
  input  logic                rst_n,
  input  tea_ctr_pkg::key_t   key,
  input  logic                vld_in,
  input  tea_ctr_pkg::lane_t  lane_in,
  output logic                vld_out,
  output tea_ctr_pkg::lane_t  lane_out
);

  // Round sum is DELTA * (round + 1) mod 2^32, fixed per stage
  localparam logic [63:0] SUM_WIDE =
    (64'(ROUND_IDX) + 64'd1) * 64'(tea_ctr_pkg::TEA_DELTA);
  localparam logic [tea_ctr_pkg::WordW-1:0] ROUND_SUM = SUM_WIDE[tea_ctr_pkg::WordW-1:0];

  logic               vld_r;
  tea_ctr_pkg::lane_t lane_r;
  tea_ctr_pkg::lane_t lane_nxt;

  // Half-round update
  always_comb begin
    lane_nxt = lane_in;
    if (ODD_HALF) begin
      lane_nxt.v1 = lane_in.v1 +
                    tea_ctr_pkg::tea_mix(lane_in.v0, key.k2, key.k3, ROUND_SUM);
    end else begin
      lane_nxt.v0 = lane_in.v0 +
                    tea_ctr_pkg::tea_mix(lane_in.v1, key.k0, key.k1, ROUND_SUM);
    end
  end

  // Valid bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_in;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    lane_r <= lane_nxt;
  end

  assign vld_out  = vld_r;
  assign lane_out = lane_r;

endmodule

// File: tb/tb_tea_ctr_keystream_cipher_top.sv
// Testbench for the counter-mode TEA cipher: directed table, random streams, predictor check.
module tb_tea_ctr_keystream_cipher_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TeaRounds   = 1024;
  localparam int unsigned PipeLatency = 2 * TeaRounds + 2;
  localparam int unsigned RandomItems = 850;
  localparam int unsigned PhaseItems  = 150;
  localparam int unsigned DirCount    = 16;

  // Indexes past the register list; writes there must be dropped
  localparam logic [tea_ctr_pkg::CfgIdxW-1:0] CFG_SPARE_FIRST = 3'd5;
  localparam logic [tea_ctr_pkg::CfgIdxW-1:0] CFG_SPARE_LAST  = 3'd7;

  typedef struct packed {
    logic [tea_ctr_pkg::BlockW-1:0] data;
    logic [tea_ctr_pkg::WordW-1:0]  index;
  } block_req_t;

  // Directed requests, run under the reset key and nonce
  localparam block_req_t DirectedReqs [DirCount] = '{
    '{64'h0000_0000_0000_0000, 32'h0000_0000},
    '{64'h0000_0000_0000_0000, 32'h0000_0001},
    '{64'hFFFF_FFFF_FFFF_FFFF, 32'h0000_0000},
    '{64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF},
    '{64'h0000_0000_0000_0000, 32'hFFFF_FFFF},
    '{64'hAAAA_AAAA_AAAA_AAAA, 32'h5555_5555},
    '{64'h5555_5555_5555_5555, 32'hAAAA_AAAA},
    '{64'h8000_0000_0000_0000, 32'h8000_0000},
    '{64'h0000_0000_0000_0001, 32'h7FFF_FFFF},
    '{64'h0123_4567_89AB_CDEF, 32'h0000_0002},
    '{64'h0123_4567_89AB_CDEF, 32'h0000_0003},
    '{64'hFEDC_BA98_7654_3210, 32'h0000_0000},
    '{64'h0000_0000_0000_0000, 32'h0000_0000},
    '{64'h0000_0000_FFFF_FFFF, 32'h0000_FFFF},
    '{64'hFFFF_FFFF_0000_0000, 32'hFFFF_0000},
    '{64'hDEAD_BEEF_CAFE_F00D, 32'h0000_0001}
  };

  logic                               clk;
  logic                               rst_n;
  logic                               start;
  logic                               busy;
  logic [tea_ctr_pkg::BlockW-1:0]     in_data_block;
  logic [tea_ctr_pkg::WordW-1:0]      in_block_index;
  logic                               out_valid;
  logic [tea_ctr_pkg::BlockW-1:0]     out_result_block;
  logic                               cfg_we;
  logic [tea_ctr_pkg::CfgIdxW-1:0]    cfg_index;
  logic [tea_ctr_pkg::BlockW-1:0]     cfg_wdata;

  // Shadow of the key and nonce registers
  logic [tea_ctr_pkg::WordW-1:0]  key_words [4];
  logic [tea_ctr_pkg::BlockW-1:0] nonce_copy;

  logic [tea_ctr_pkg::BlockW-1:0] pending_blocks [$];
  logic [tea_ctr_pkg::BlockW-1:0] expected_block;
  int unsigned                    mismatch_count;
  logic [tea_ctr_pkg::WordW-1:0]  msg_pos;
  bit                             burst;

  tea_ctr_keystream_cipher_top #(
    .ROUNDS(TeaRounds)
  ) DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_data_block    (in_data_block),
    .in_block_index   (in_block_index),
    .out_valid        (out_valid),
    .out_result_block (out_result_block),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Run limit, far beyond the slowest legal run
  initial begin
    #3_000_000;
    $display("Mismatches found");
    $finish;
  end

  // Counter block enciphered with TEA, XORed into the data block
  function automatic logic [tea_ctr_pkg::BlockW-1:0] tea_ctr_result(
    input logic [tea_ctr_pkg::BlockW-1:0] data,
    input logic [tea_ctr_pkg::WordW-1:0]  index
  );
    logic [tea_ctr_pkg::BlockW-1:0] ctr;
    logic [tea_ctr_pkg::WordW-1:0]  v0;
    logic [tea_ctr_pkg::WordW-1:0]  v1;
    logic [tea_ctr_pkg::WordW-1:0]  sum;
    ctr = {{(tea_ctr_pkg::BlockW-tea_ctr_pkg::WordW){1'b0}}, index} ^ nonce_copy;
    v0  = ctr[tea_ctr_pkg::WordW-1:0];
    v1  = ctr[tea_ctr_pkg::BlockW-1:tea_ctr_pkg::WordW];
    sum = '0;
    for (int r = 0; r < TeaRounds; r++) begin
      sum = sum + tea_ctr_pkg::TEA_DELTA;
      v0  = v0 + (((v1 << 4) + key_words[0]) ^ (v1 + sum) ^ ((v1 >> 5) + key_words[1]));
      v1  = v1 + (((v0 << 4) + key_words[2]) ^ (v0 + sum) ^ ((v0 >> 5) + key_words[3]));
    end
    return data ^ {v1, v0};
  endfunction

  // Wait gap: zero through bursts, else drawn at random
  function automatic int unsigned draw_gap();
    if ($urandom_range(0, 39) == 0) burst = ~burst;
    return burst ? 0 : $urandom_range(0, 5);
  endfunction

  // One register write; cfg_we stays high for back-to-back writes
  task automatic write_reg(input logic [tea_ctr_pkg::CfgIdxW-1:0] idx,
                           input logic [tea_ctr_pkg::BlockW-1:0]  value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    case (idx)
      tea_ctr_pkg::CFG_KEY0:  key_words[0] = value[tea_ctr_pkg::WordW-1:0];
      tea_ctr_pkg::CFG_KEY1:  key_words[1] = value[tea_ctr_pkg::WordW-1:0];
      tea_ctr_pkg::CFG_KEY2:  key_words[2] = value[tea_ctr_pkg::WordW-1:0];
      tea_ctr_pkg::CFG_KEY3:  key_words[3] = value[tea_ctr_pkg::WordW-1:0];
      tea_ctr_pkg::CFG_NONCE: nonce_copy = value;
      default: ;
    endcase
  endtask

  // Full key/nonce setting; keys carry junk upper bits, spare indexes get junk too
  task automatic set_config(input logic [tea_ctr_pkg::WordW-1:0]  k0,
                            input logic [tea_ctr_pkg::WordW-1:0]  k1,
                            input logic [tea_ctr_pkg::WordW-1:0]  k2,
                            input logic [tea_ctr_pkg::WordW-1:0]  k3,
                            input logic [tea_ctr_pkg::BlockW-1:0] nonce);
    write_reg(tea_ctr_pkg::CFG_KEY0, {$urandom, k0});
    write_reg(tea_ctr_pkg::CFG_KEY1, {$urandom, k1});
    write_reg(tea_ctr_pkg::CFG_KEY2, {$urandom, k2});
    write_reg(tea_ctr_pkg::CFG_KEY3, {$urandom, k3});
    write_reg(tea_ctr_pkg::CFG_NONCE, nonce);
    for (int s = CFG_SPARE_FIRST; s <= CFG_SPARE_LAST; s++) begin
      write_reg(s[tea_ctr_pkg::CfgIdxW-1:0], {$urandom, $urandom});
    end
    cfg_we <= 1'b0;
  endtask

  // Issue one request and record its expected result on acceptance
  task automatic send_block(input logic [tea_ctr_pkg::BlockW-1:0] data,
                            input logic [tea_ctr_pkg::WordW-1:0]  index,
                            input int unsigned                    gap);
    if (gap != 0) begin
      if (start) start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start          <= 1'b1;
    in_data_block  <= data;
    in_block_index <= index;
    do @(posedge clk); while (busy);
    pending_blocks.push_back(tea_ctr_result(data, index));
  endtask

  // Stop requests and wait for every result in flight
  task automatic drain_pipe();
    start <= 1'b0;
    do @(posedge clk); while (pending_blocks.size() != 0);
  endtask

  // Result check against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_blocks.size() == 0) begin
        mismatch_count++;
        $error("result_block: no request pending, actual %h", out_result_block);
      end else begin
        expected_block = pending_blocks.pop_front();
        if (out_result_block !== expected_block) begin
          mismatch_count++;
          $error("result_block: expected %h, actual %h", expected_block, out_result_block);
        end
      end
    end
  end

  // Stimulus
  initial begin
    logic [tea_ctr_pkg::BlockW-1:0] data;
    logic [tea_ctr_pkg::WordW-1:0]  index;
    int unsigned                    pick;
    rst_n          <= 1'b0;
    start          <= 1'b0;
    in_data_block  <= '0;
    in_block_index <= '0;
    cfg_we         <= 1'b0;
    cfg_index      <= '0;
    cfg_wdata      <= '0;
    for (int k = 0; k < 4; k++) key_words[k] = '0;
    nonce_copy     = '0;
    mismatch_count = 0;
    msg_pos        = '0;
    burst          = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table under reset key and nonce
    for (int d = 0; d < DirCount; d++) begin
      send_block(DirectedReqs[d].data, DirectedReqs[d].index, draw_gap());
    end

    for (int n = 0; n < RandomItems; n++) begin
      // New key/nonce setting per phase, only with the pipeline empty
      if (n % PhaseItems == 0) begin
        drain_pipe();
        case (n / PhaseItems)
          0: set_config('1, '1, '1, '1, '1);
          1: set_config($urandom, $urandom, $urandom, $urandom, {$urandom, $urandom});
          2: set_config($urandom, $urandom, $urandom, $urandom, '0);
          3: set_config('0, '0, '0, '0, {$urandom, $urandom});
          4: set_config(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA,
                        64'hFFFF_FFFF_0000_0000);
          default: set_config($urandom, $urandom, $urandom, $urandom, {$urandom, $urandom});
        endcase
        msg_pos = '0;
      end

      // Mostly consecutive block indexes of a message, some random, some extremes
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
        index   = msg_pos;
        msg_pos = msg_pos + 1'b1;
        if ($urandom_range(0, 30) == 0) begin
          msg_pos = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFF0 : '0;
        end
      end else if (pick < 9) begin
        index = $urandom;
      end else begin
        case ($urandom_range(0, 3))
          0: index = '0;
          1: index = '1;
          2: index = 32'h8000_0000;
          default: index = 32'h7FFF_FFFF;
        endcase
      end

      pick = $urandom_range(0, 19);
      if (pick == 0)      data = '0;
      else if (pick == 1) data = '1;
      else                data = {$urandom, $urandom};

      send_block(data, index, draw_gap());
    end

    drain_pipe();
    repeat (PipeLatency + 16) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
